FILE: rtl/ldn_pkg.sv
// Shared types, constants and register codes for the lidar deskew block.
`timescale 1ns / 1ps
`default_nettype none

package ldn_pkg;

  localparam int MAX_KEYFRAMES_DEF = 128;
  localparam int FIFO_DEPTH        = 4;
  localparam int ROT_FRAC          = 28;
  localparam logic [63:0] ARM_MIN_SQ = 64'd4295;

  typedef enum logic [2:0] {
    REG_SWEEP_START = 3'd0,
    REG_STEP_TIME   = 3'd1,
    REG_KEY_COUNT   = 3'd2,
    REG_TRANS_EN    = 3'd3,
    REG_ARM_X       = 3'd4,
    REG_ARM_Y       = 3'd5,
    REG_ARM_Z       = 3'd6
  } reg_idx_t;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_POINT   = 1'b1;
  localparam logic KIND_ACK   = 1'b0;
  localparam logic KIND_POINT = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [6:0]         key_index;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [47:0]        point_time_us;
  } in_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
  } out_t;

  // Item payload that travels down the back pipeline.
  typedef struct packed {
    logic               kind;
    logic [6:0]         key;
    logic [63:0]        quat;   // {z, y, x, w}, w in the low bits
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } side_t;

  typedef struct packed {
    side_t       side;
    logic [63:0] elapsed;  // 1/65536 us since sweep start, zero before it
  } ent_t;

  typedef struct packed {
    logic             valid;
    side_t            side;
    logic [8:0][33:0] m;
    logic [32:0]      n;
  } nd_in_t;

  typedef struct packed {
    logic             valid;
    side_t            side;
    logic [8:0][29:0] r;
  } nd_out_t;

endpackage

`default_nettype wire

FILE: rtl/ldn_front.sv
// Input side: classifies items and forms the elapsed time of each point.
`timescale 1ns / 1ps
`default_nettype none

module ldn_front (
  input  logic          item_valid,
  output logic          item_ready,
  input  ldn_pkg::in_t  item,
  input  logic [47:0]   sweep_start_us,
  input  logic          q_ready,
  output logic          push,
  output ldn_pkg::ent_t entry
);

  always_comb begin
    item_ready = q_ready;
    push       = item_valid && q_ready;
    entry.side.kind = (item.opcode == ldn_pkg::OP_POINT) ? ldn_pkg::KIND_POINT
                                                         : ldn_pkg::KIND_ACK;
    entry.side.key  = item.key_index;
    entry.side.quat = {item.quat_z, item.quat_y, item.quat_x, item.quat_w};
    entry.side.px   = item.point_x;
    entry.side.py   = item.point_y;
    entry.side.pz   = item.point_z;
    // Points taken before the sweep start clamp to the first keyframe.
    if (item.opcode == ldn_pkg::OP_POINT && item.point_time_us >= sweep_start_us) begin
      entry.elapsed = {item.point_time_us - sweep_start_us, 16'd0};
    end else begin
      entry.elapsed = 64'd0;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ldn_fifo.sv
// Short item queue between the front and the back pipeline.
`timescale 1ns / 1ps
`default_nettype none

module ldn_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ldn_pkg::ent_t push_entry,
  output logic          not_full,
  input  logic          pop,
  output logic          head_valid,
  output ldn_pkg::ent_t head
);

  localparam int DEPTH = ldn_pkg::FIFO_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  ldn_pkg::ent_t slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign not_full   = (count != CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ldn_ndiv.sv
// Nine-lane pipelined divider that normalizes the rotation matrix to Q2.28.
`timescale 1ns / 1ps
`default_nettype none

module ldn_ndiv (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  ldn_pkg::nd_in_t  din,
  output ldn_pkg::nd_out_t dout
);

  localparam int QB = ldn_pkg::ROT_FRAC + 1;

  typedef struct packed {
    logic                 valid;
    ldn_pkg::side_t       side;
    logic [32:0]          n;
    logic [8:0]           neg;
    logic [8:0][32:0]     r;
    logic [8:0][QB-1:0]   lo;
  } st_t;

  st_t st [QB+1];
  st_t st0_next;

  // Numerator |m| * 2^28 + n/2 rounds the quotient half away from zero.
  always_comb begin
    logic [33:0] mag;
    logic [61:0] num;
    st0_next.valid = din.valid;
    st0_next.side  = din.side;
    st0_next.n     = din.n;
    for (int l = 0; l < 9; l++) begin
      mag = din.m[l][33] ? (34'd0 - din.m[l]) : din.m[l];
      num = 62'({mag[32:0], 28'd0}) + 62'(din.n[32:1]);
      st0_next.neg[l] = din.m[l][33];
      st0_next.r[l]   = num[61:QB];
      st0_next.lo[l]  = num[QB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st[0].valid <= 1'b0;
    end else if (adv) begin
      st[0] <= st0_next;
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_step
    st_t nx;
    always_comb begin
      logic [33:0] t;
      nx = st[j];
      for (int l = 0; l < 9; l++) begin
        t = {st[j].r[l], st[j].lo[l][QB-1]};
        if (t >= {1'b0, st[j].n}) begin
          nx.r[l]  = 33'(t - {1'b0, st[j].n});
          nx.lo[l] = {st[j].lo[l][QB-2:0], 1'b1};
        end else begin
          nx.r[l]  = t[32:0];
          nx.lo[l] = {st[j].lo[l][QB-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        st[j+1].valid <= 1'b0;
      end else if (adv) begin
        st[j+1] <= nx;
      end
    end
  end

  ldn_pkg::nd_out_t dout_next;

  // An all-zero blend leaves the point unrotated.
  always_comb begin
    dout_next.valid = st[QB].valid;
    dout_next.side  = st[QB].side;
    for (int l = 0; l < 9; l++) begin
      if (st[QB].n == '0) begin
        dout_next.r[l] = (l == 0 || l == 4 || l == 8) ? (30'(1) << ldn_pkg::ROT_FRAC)
                                                       : 30'd0;
      end else if (st[QB].neg[l]) begin
        dout_next.r[l] = 30'd0 - 30'(st[QB].lo[l]);
      end else begin
        dout_next.r[l] = 30'(st[QB].lo[l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (adv) begin
      dout <= dout_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ldn_back.sv
// Back pipeline: interval search, keyframe table, blend, normalize and rotate.
`timescale 1ns / 1ps
`default_nettype none

module ldn_back #(
  parameter int MAX_KEYFRAMES = ldn_pkg::MAX_KEYFRAMES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  ldn_pkg::ent_t      q_entry,
  output logic               q_pop,
  input  logic [31:0]        step_time,
  input  logic [7:0]         keyframe_count,
  input  logic               use_arm,
  input  logic signed [31:0] arm_x,
  input  logic signed [31:0] arm_y,
  input  logic signed [31:0] arm_z,
  output logic               result_valid,
  input  logic               result_ready,
  output ldn_pkg::out_t      result
);

  localparam int KW  = $clog2(MAX_KEYFRAMES);
  localparam int RW  = 32 + KW;
  localparam int NDS = KW + 16;

  logic adv;
  assign adv   = !result_valid || result_ready;
  assign q_pop = adv && q_valid;

  logic [31:0]   step_eff;
  logic [KW-1:0] kmax;

  always_comb begin
    step_eff = (step_time == 32'd0) ? 32'd1 : step_time;
    if (keyframe_count < 8'd2) begin
      kmax = '0;
    end else if (32'(keyframe_count) > MAX_KEYFRAMES) begin
      kmax = KW'(MAX_KEYFRAMES - 2);
    end else begin
      kmax = KW'(keyframe_count - 8'd2);
    end
  end

  // Interval search: KW integer quotient bits, then 16 weight bits.
  typedef struct packed {
    logic           valid;
    ldn_pkg::side_t side;
    logic           ovf;
    logic [RW-1:0]  rem;
    logic [KW-1:0]  q;
    logic [15:0]    f;
  } dv_t;

  dv_t dv [NDS+1];
  dv_t dv0_next;

  always_comb begin
    dv0_next.valid = q_valid;
    dv0_next.side  = q_entry.side;
    dv0_next.ovf   = (q_entry.elapsed >= ({32'd0, step_eff} << KW));
    dv0_next.rem   = q_entry.elapsed[RW-1:0];
    dv0_next.q     = '0;
    dv0_next.f     = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0].valid <= 1'b0;
    end else if (adv) begin
      dv[0] <= dv0_next;
    end
  end

  for (genvar j = 0; j < NDS; j++) begin : g_div
    dv_t nx;
    if (j < KW) begin : g_int
      localparam int B = KW - 1 - j;
      logic [RW-1:0] sh;
      always_comb begin
        sh = RW'(step_eff) << B;
        nx = dv[j];
        if (dv[j].rem >= sh) begin
          nx.rem  = dv[j].rem - sh;
          nx.q[B] = 1'b1;
        end
      end
    end else begin : g_frac
      localparam int B = 15 - (j - KW);
      logic [32:0] t;
      always_comb begin
        t  = {dv[j].rem[31:0], 1'b0};
        nx = dv[j];
        if (t >= {1'b0, step_eff}) begin
          nx.rem  = RW'(t - {1'b0, step_eff});
          nx.f[B] = 1'b1;
        end else begin
          nx.rem = RW'(t);
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[j+1].valid <= 1'b0;
      end else if (adv) begin
        dv[j+1] <= nx;
      end
    end
  end

  typedef struct packed {
    logic           valid;
    ldn_pkg::side_t side;
    logic [KW-1:0]  k;
    logic [16:0]    alpha;
  } kc_t;

  kc_t kc;
  kc_t kc_next;

  always_comb begin
    kc_next.valid = dv[NDS].valid;
    kc_next.side  = dv[NDS].side;
    if (dv[NDS].ovf || dv[NDS].q > kmax) begin
      kc_next.k     = kmax;
      kc_next.alpha = 17'h10000;
    end else begin
      kc_next.k     = dv[NDS].q;
      kc_next.alpha = {1'b0, dv[NDS].f};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kc.valid <= 1'b0;
    end else if (adv) begin
      kc <= kc_next;
    end
  end

  // Keyframe table: one write and two registered reads per cycle while the pipeline advances.
  typedef struct packed {
    logic           valid;
    ldn_pkg::side_t side;
    logic [16:0]    alpha;
  } mr_t;

  mr_t           mr;
  logic [63:0]   tbl [MAX_KEYFRAMES];
  logic [63:0]   qa;
  logic [63:0]   qb;
  logic [KW-1:0] k1;
  logic          wr_en;
  logic [KW-1:0] wr_addr;

  always_comb begin
    k1      = kc.k + KW'(1);
    wr_en   = kc.valid && (kc.side.kind == ldn_pkg::KIND_ACK) &&
              (32'(kc.side.key) < MAX_KEYFRAMES);
    wr_addr = KW'(kc.side.key);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      qa <= tbl[kc.k];
      qb <= tbl[k1];
      if (wr_en) tbl[wr_addr] <= kc.side.quat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mr.valid <= 1'b0;
    end else if (adv) begin
      mr.valid <= kc.valid;
      mr.side  <= kc.side;
      mr.alpha <= kc.alpha;
    end
  end

  typedef struct packed {
    logic             valid;
    ldn_pkg::side_t   side;
    logic [3:0][33:0] pa;
    logic [3:0][33:0] pb;
  } bl_t;

  bl_t bl;
  bl_t bl_next;

  always_comb begin
    logic [16:0] wa;
    wa = 17'h10000 - mr.alpha;
    bl_next.valid = mr.valid;
    bl_next.side  = mr.side;
    for (int i = 0; i < 4; i++) begin
      bl_next.pa[i] = $signed(qa[16*i +: 16]) * $signed({1'b0, wa});
      bl_next.pb[i] = $signed(qb[16*i +: 16]) * $signed({1'b0, mr.alpha});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bl.valid <= 1'b0;
    end else if (adv) begin
      bl <= bl_next;
    end
  end

  typedef struct packed {
    logic             valid;
    ldn_pkg::side_t   side;
    logic [3:0][15:0] c;
  } cs_t;

  cs_t cs;
  cs_t cs_next;

  always_comb begin
    logic signed [34:0] s;
    cs_next.valid = bl.valid;
    cs_next.side  = bl.side;
    for (int i = 0; i < 4; i++) begin
      s = 35'($signed(bl.pa[i])) + 35'($signed(bl.pb[i])) + 35'sd32768;
      cs_next.c[i] = s[31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cs.valid <= 1'b0;
    end else if (adv) begin
      cs <= cs_next;
    end
  end

  // Products: ww xx yy zz xy wz xz wy yz wx.
  typedef struct packed {
    logic             valid;
    ldn_pkg::side_t   side;
    logic [9:0][31:0] p;
  } pr_t;

  pr_t pr;
  pr_t pr_next;

  always_comb begin
    logic signed [15:0] w, x, y, z;
    w = $signed(cs.c[0]);
    x = $signed(cs.c[1]);
    y = $signed(cs.c[2]);
    z = $signed(cs.c[3]);
    pr_next.valid = cs.valid;
    pr_next.side  = cs.side;
    pr_next.p[0]  = w * w;
    pr_next.p[1]  = x * x;
    pr_next.p[2]  = y * y;
    pr_next.p[3]  = z * z;
    pr_next.p[4]  = x * y;
    pr_next.p[5]  = w * z;
    pr_next.p[6]  = x * z;
    pr_next.p[7]  = w * y;
    pr_next.p[8]  = y * z;
    pr_next.p[9]  = w * x;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pr.valid <= 1'b0;
    end else if (adv) begin
      pr <= pr_next;
    end
  end

  ldn_pkg::nd_in_t md;
  ldn_pkg::nd_in_t md_next;

  always_comb begin
    logic signed [33:0] ww, xx, yy, zz, xy, wz, xz, wy, yz, wx;
    ww = 34'($signed(pr.p[0]));
    xx = 34'($signed(pr.p[1]));
    yy = 34'($signed(pr.p[2]));
    zz = 34'($signed(pr.p[3]));
    xy = 34'($signed(pr.p[4]));
    wz = 34'($signed(pr.p[5]));
    xz = 34'($signed(pr.p[6]));
    wy = 34'($signed(pr.p[7]));
    yz = 34'($signed(pr.p[8]));
    wx = 34'($signed(pr.p[9]));
    md_next.valid = pr.valid;
    md_next.side  = pr.side;
    md_next.m[0]  = ww + xx - yy - zz;
    md_next.m[1]  = (xy - wz) <<< 1;
    md_next.m[2]  = (xz + wy) <<< 1;
    md_next.m[3]  = (xy + wz) <<< 1;
    md_next.m[4]  = ww - xx + yy - zz;
    md_next.m[5]  = (yz - wx) <<< 1;
    md_next.m[6]  = (xz - wy) <<< 1;
    md_next.m[7]  = (yz + wx) <<< 1;
    md_next.m[8]  = ww - xx - yy + zz;
    md_next.n     = 33'(pr.p[0]) + 33'(pr.p[1]) + 33'(pr.p[2]) + 33'(pr.p[3]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      md.valid <= 1'b0;
    end else if (adv) begin
      md <= md_next;
    end
  end

  ldn_pkg::nd_out_t nd;

  ldn_ndiv u_ndiv (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .din  (md),
    .dout (nd)
  );

  typedef struct packed {
    logic             valid;
    logic             kind;
    logic [8:0][29:0] r;
    logic [2:0][32:0] p;
  } rp_t;

  rp_t rp;
  rp_t rp_next;

  always_comb begin
    rp_next.valid = nd.valid;
    rp_next.kind  = nd.side.kind;
    rp_next.r     = nd.r;
    rp_next.p[0]  = 33'($signed(nd.side.px)) + (use_arm ? 33'(arm_x) : 33'sd0);
    rp_next.p[1]  = 33'($signed(nd.side.py)) + (use_arm ? 33'(arm_y) : 33'sd0);
    rp_next.p[2]  = 33'($signed(nd.side.pz)) + (use_arm ? 33'(arm_z) : 33'sd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rp.valid <= 1'b0;
    end else if (adv) begin
      rp <= rp_next;
    end
  end

  typedef struct packed {
    logic             valid;
    logic             kind;
    logic [8:0][62:0] prod;
  } mu_t;

  mu_t mu;
  mu_t mu_next;

  always_comb begin
    mu_next.valid = rp.valid;
    mu_next.kind  = rp.kind;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        mu_next.prod[i*3+j] = $signed(rp.r[i*3+j]) * $signed(rp.p[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mu.valid <= 1'b0;
    end else if (adv) begin
      mu <= mu_next;
    end
  end

  function automatic logic [31:0] sat32(input logic signed [36:0] v);
    if (v > 37'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (v < -37'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  ldn_pkg::out_t res_next;

  always_comb begin
    logic signed [63:0] acc;
    logic signed [36:0] v;
    logic signed [31:0] arm [3];
    logic [31:0]        o [3];
    arm[0] = arm_x;
    arm[1] = arm_y;
    arm[2] = arm_z;
    for (int i = 0; i < 3; i++) begin
      acc = 64'($signed(mu.prod[i*3])) + 64'($signed(mu.prod[i*3+1])) +
            64'($signed(mu.prod[i*3+2])) + (64'sd1 <<< (ldn_pkg::ROT_FRAC - 1));
      v   = 37'($signed(acc[63:ldn_pkg::ROT_FRAC]));
      if (use_arm) v = v - 37'(arm[i]);
      o[i] = (mu.kind == ldn_pkg::KIND_POINT) ? sat32(v) : 32'd0;
    end
    res_next.result_kind = mu.kind;
    res_next.out_x       = o[0];
    res_next.out_y       = o[1];
    res_next.out_z       = o[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= mu.valid;
      result       <= res_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lidar_point_deskew_nlerp.sv
// Top level of the lidar point deskew block: registers and the three parts.
//
//  channel   signals                                 direction  moves
//  item      item_valid / item_ready / item          in         keyframe load or point
//  result    result_valid / result_ready / result    out        ack or corrected point
//  cfg       cfg_valid / cfg_ready / cfg_index/data  in         register write
//
// One item is accepted per clock while the queue has room; every back stage, the
// interval divider (log2(MAX_KEYFRAMES) + 16 one-bit steps) and the 29-step
// normalizing divider included, moves one item a cycle while results are taken.
// Synchronous reset clears the queue, valid bits and registers, not the table.
// A held result freezes the back pipeline; the front fills the four-entry queue.
`timescale 1ns / 1ps
`default_nettype none

module lidar_point_deskew_nlerp #(
  parameter int MAX_KEYFRAMES = ldn_pkg::MAX_KEYFRAMES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_ready,
  input  ldn_pkg::in_t  item,
  output logic          result_valid,
  input  logic          result_ready,
  output ldn_pkg::out_t result,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [47:0]   cfg_data
);

  // Configuration registers. The user must write them only while the block is idle,
  // which the block does not enforce; the pipeline reads them directly, not copied per item.
  logic [47:0]        sweep_start_us;
  logic [31:0]        step_time;
  logic [7:0]         keyframe_count;
  logic               translation_enable;
  logic signed [31:0] arm_x;
  logic signed [31:0] arm_y;
  logic signed [31:0] arm_z;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_start_us     <= 48'd0;
      step_time          <= 32'd65536;
      keyframe_count     <= 8'd2;
      translation_enable <= 1'b0;
      arm_x              <= 32'sd0;
      arm_y              <= 32'sd0;
      arm_z              <= 32'sd0;
    end else if (cfg_valid) begin
      unique case (ldn_pkg::reg_idx_t'(cfg_index))
        ldn_pkg::REG_SWEEP_START: sweep_start_us     <= cfg_data;
        ldn_pkg::REG_STEP_TIME:   step_time          <= cfg_data[31:0];
        ldn_pkg::REG_KEY_COUNT:   keyframe_count     <= cfg_data[7:0];
        ldn_pkg::REG_TRANS_EN:    translation_enable <= cfg_data[0];
        ldn_pkg::REG_ARM_X:       arm_x              <= cfg_data[31:0];
        ldn_pkg::REG_ARM_Y:       arm_y              <= cfg_data[31:0];
        ldn_pkg::REG_ARM_Z:       arm_z              <= cfg_data[31:0];
        default: begin
        end
      endcase
    end
  end

  // The lever arm is applied only when it is longer than about 1 mm. The
  // squared length is formed in two registered steps after each write.
  logic [63:0] sq_x;
  logic [63:0] sq_y;
  logic [63:0] sq_z;
  logic        use_arm;

  always_ff @(posedge clk) begin
    sq_x <= 64'(arm_x * arm_x);
    sq_y <= 64'(arm_y * arm_y);
    sq_z <= 64'(arm_z * arm_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      use_arm <= 1'b0;
    end else begin
      use_arm <= translation_enable && ((sq_x + sq_y + sq_z) >= ldn_pkg::ARM_MIN_SQ);
    end
  end

  // Front: classify and timestamp, then queue.
  logic          q_ready;
  logic          push;
  ldn_pkg::ent_t push_entry;
  logic          q_pop;
  logic          q_valid;
  ldn_pkg::ent_t q_head;

  ldn_front u_front (
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .item           (item),
    .sweep_start_us (sweep_start_us),
    .q_ready        (q_ready),
    .push           (push),
    .entry          (push_entry)
  );

  ldn_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .not_full   (q_ready),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  // Back: keyframe table writes and point correction, in arrival order so a
  // load always lands before any later point reads the table.
  ldn_back #(
    .MAX_KEYFRAMES (MAX_KEYFRAMES)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_entry        (q_head),
    .q_pop          (q_pop),
    .step_time      (step_time),
    .keyframe_count (keyframe_count),
    .use_arm        (use_arm),
    .arm_x          (arm_x),
    .arm_y          (arm_y),
    .arm_z          (arm_z),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .result         (result)
  );

endmodule

`default_nettype wire
